### src/spfp_pkg.sv
package spfp_pkg;

	// Fixed widths of the channel payloads.
	localparam int SAMPLE_W   = 32;
	localparam int QSAMPLE_W  = 16;
	localparam int BYTE_W     = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;
	localparam int LEN_CFG_W  = 4;

	// Two channels per sample pair, packed a then b in one buffer row.
	localparam int CHANNELS = 2;
	localparam int ROW_W    = CHANNELS * QSAMPLE_W;

	// Packet framing.
	localparam logic [BYTE_W-1:0] PKT_MARK   = 8'h73;
	localparam logic [15:0]       CHAN_COUNT = 16'(CHANNELS);
	localparam logic [2:0]        HDR_LAST   = 3'd7;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_CAPTURE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STREAM  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LENGTH  = 2'd2;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_QUANT,
		ST_HEAD,
		ST_BODY
	} state_t;

endpackage

### src/spfp_sample_if.sv
interface spfp_sample_if
	import spfp_pkg::*;
;
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] chan_a_sample;
	logic signed [SAMPLE_W-1:0] chan_b_sample;

	modport source (output valid, output chan_a_sample, output chan_b_sample, input ready);
	modport sink (input valid, input chan_a_sample, input chan_b_sample, output ready);
endinterface

### src/spfp_packet_if.sv
interface spfp_packet_if
	import spfp_pkg::*;
;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] packet_byte;
	logic              packet_last;

	modport source (output valid, output packet_byte, output packet_last, input ready);
	modport sink (input valid, input packet_byte, input packet_last, output ready);
endinterface

### src/spfp_cfg_if.sv
interface spfp_cfg_if
	import spfp_pkg::*;
;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

### src/spfp_ram.sv
module spfp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 12,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// One write port, one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### src/spfp_quant.sv
module spfp_quant
	import spfp_pkg::*;
#(
	parameter int FRAC_BITS = 8
) (
	input  logic signed [SAMPLE_W-1:0] raw,
	output logic [QSAMPLE_W-1:0]       q
);

	localparam logic [SAMPLE_W:0] HALF     = (33'd1 << FRAC_BITS) >> 1;
	localparam logic [SAMPLE_W:0] HALF_INC = HALF + 33'd1;

	logic            neg;
	logic [SAMPLE_W:0] sum;
	logic [SAMPLE_W:0] mag_q;

	// Magnitude plus one half in a single adder: for a negative value the
	// magnitude is the inverted bits plus one, folded into the constant.
	always_comb begin
		neg   = raw[SAMPLE_W-1];
		sum   = neg ? ({1'b0, ~raw} + HALF_INC) : ({1'b0, raw} + HALF);
		mag_q = sum >> FRAC_BITS;
		if (neg) begin
			if (mag_q >= 33'd32768) begin
				q = 16'h8000;
			end else begin
				q = 16'(-mag_q[QSAMPLE_W-1:0]);
			end
		end else begin
			if (mag_q > 33'd32767) begin
				q = 16'h7fff;
			end else begin
				q = mag_q[QSAMPLE_W-1:0];
			end
		end
	end

endmodule

### src/sample_pair_frame_packetizer.sv
// Sample pair frame packetizer. Each accepted word carries one sample of each
// of two channels; while capture is enabled both are rounded half away from
// zero, saturated to signed 16 bits and written as one row of the frame
// buffer RAM. A sample word is first registered, then quantized and written,
// and the input takes no new word until the last one is written. When the
// buffer holds frame_length pairs and streaming is enabled, the block sends
// 8 + 4 * frame_length bytes, one per output word: 0x73, the 32-bit sequence
// number big-endian, the pair count, the channel count 2 as 16 bits, then each
// sample big-endian, channel a before channel b. The byte sequencer reads one
// buffer row per pair and sends one byte per cycle when the sink keeps ready
// high; the input is held off until the last byte is loaded into the output
// register. With streaming disabled a full frame is dropped and the sequence
// number stays. A capture, stream or length write restarts the fill. Writes with
// capture disabled are accepted and discarded. The buffer needs no clearing
// after reset.
module sample_pair_frame_packetizer
	import spfp_pkg::*;
#(
	parameter int MAX_FRAME_PAIRS = 12,
	parameter int FRAC_BITS       = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	spfp_cfg_if.sink      cfg,
	spfp_sample_if.sink   samples,
	spfp_packet_if.source packets
);

	localparam int AW = (MAX_FRAME_PAIRS > 1) ? $clog2(MAX_FRAME_PAIRS) : 1;
	localparam int CW = $clog2(MAX_FRAME_PAIRS + 1);
	localparam logic [LEN_CFG_W-1:0] MAX_LEN = LEN_CFG_W'(MAX_FRAME_PAIRS);

	state_t state_q, state_d;

	logic          capture_q;
	logic          stream_q;
	logic [CW-1:0] len_q;
	logic [CW-1:0] fill_q;
	logic [31:0]   seq_q;
	logic [2:0]    hdr_q;
	logic [AW-1:0] pair_q;
	logic [1:0]    bsel_q;

	logic signed [SAMPLE_W-1:0] a_s1, b_s1;
	logic [QSAMPLE_W-1:0]       qa, qb;

	logic              out_valid_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic              out_last_q;

	logic              cfg_we;
	logic [LEN_CFG_W-1:0] len_cfg;
	logic [LEN_CFG_W-1:0] len_clamp;
	logic [CW-1:0]     fill_inc;
	logic              frame_done;
	logic              pair_last;
	logic              can_load;
	logic              take_in;
	logic              ram_we;
	logic              out_load;
	logic [BYTE_W-1:0] out_byte_d;
	logic              out_last_d;
	logic              rd_en;
	logic [AW-1:0]     rd_addr;
	logic [ROW_W-1:0]  rd_row;

	// Configuration is always taken.
	assign cfg.ready = 1'b1;
	assign cfg_we    = cfg.valid;

	// Clamp the requested frame length to one through the buffer depth.
	always_comb begin
		len_cfg = cfg.data[LEN_CFG_W-1:0];
		if (len_cfg == '0) begin
			len_clamp = LEN_CFG_W'(1);
		end else if (len_cfg > MAX_LEN) begin
			len_clamp = MAX_LEN;
		end else begin
			len_clamp = len_cfg;
		end
	end

	// Quantizers for both channels of the registered word.
	spfp_quant #(.FRAC_BITS(FRAC_BITS)) u_quant_a (.raw(a_s1), .q(qa));
	spfp_quant #(.FRAC_BITS(FRAC_BITS)) u_quant_b (.raw(b_s1), .q(qb));

	// Frame buffer: one row per sample pair.
	spfp_ram #(.WIDTH(ROW_W), .DEPTH(MAX_FRAME_PAIRS)) u_frame_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (fill_q[AW-1:0]),
		.wdata ({qa, qb}),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_row)
	);

	assign fill_inc   = fill_q + CW'(1);
	assign frame_done = (fill_inc == len_q);
	assign pair_last  = (CW'(pair_q) == len_q - CW'(1));
	assign can_load   = !out_valid_q || packets.ready;

	// Next state, buffer access and byte selection.
	always_comb begin
		state_d    = state_q;
		take_in    = 1'b0;
		ram_we     = 1'b0;
		out_load   = 1'b0;
		out_byte_d = '0;
		out_last_d = 1'b0;
		rd_en      = 1'b0;
		rd_addr    = pair_q + AW'(1);
		case (state_q)
			ST_IDLE: begin
				take_in = 1'b1;
				if (samples.valid && capture_q) begin
					state_d = ST_QUANT;
				end
			end
			ST_QUANT: begin
				ram_we = 1'b1;
				if (frame_done && stream_q) begin
					state_d = ST_HEAD;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_HEAD: begin
				if (can_load) begin
					out_load = 1'b1;
					case (hdr_q)
						3'd0:    out_byte_d = PKT_MARK;
						3'd1:    out_byte_d = seq_q[31:24];
						3'd2:    out_byte_d = seq_q[23:16];
						3'd3:    out_byte_d = seq_q[15:8];
						3'd4:    out_byte_d = seq_q[7:0];
						3'd5:    out_byte_d = BYTE_W'(len_q);
						3'd6:    out_byte_d = CHAN_COUNT[15:8];
						default: out_byte_d = CHAN_COUNT[7:0];
					endcase
					// Fetch the first row while the last header byte goes out.
					if (hdr_q == HDR_LAST) begin
						rd_en   = 1'b1;
						rd_addr = '0;
						state_d = ST_BODY;
					end
				end
			end
			ST_BODY: begin
				if (can_load) begin
					out_load = 1'b1;
					case (bsel_q)
						2'd0:    out_byte_d = rd_row[31:24];
						2'd1:    out_byte_d = rd_row[23:16];
						2'd2:    out_byte_d = rd_row[15:8];
						default: out_byte_d = rd_row[7:0];
					endcase
					if (bsel_q == 2'd3) begin
						if (pair_last) begin
							out_last_d = 1'b1;
							state_d    = ST_IDLE;
						end else begin
							rd_en = 1'b1;
						end
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign samples.ready = take_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Control registers: configuration, fill, sequence and byte counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capture_q   <= 1'b0;
			stream_q    <= 1'b0;
			len_q       <= CW'(3);
			fill_q      <= '0;
			seq_q       <= '0;
			hdr_q       <= '0;
			pair_q      <= '0;
			bsel_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg.index)
					REG_CAPTURE: begin
						capture_q <= cfg.data[0];
						fill_q    <= '0;
					end
					REG_STREAM: begin
						stream_q <= cfg.data[0];
						fill_q   <= '0;
					end
					REG_LENGTH: begin
						len_q  <= CW'(len_clamp);
						fill_q <= '0;
					end
					default: begin
					end
				endcase
			end else if (ram_we) begin
				fill_q <= frame_done ? '0 : fill_inc;
			end

			if (ram_we) begin
				hdr_q  <= '0;
				pair_q <= '0;
				bsel_q <= '0;
			end else if (out_load && state_q == ST_HEAD) begin
				hdr_q <= hdr_q + 3'd1;
			end else if (out_load && state_q == ST_BODY) begin
				bsel_q <= bsel_q + 2'd1;
				if (bsel_q == 2'd3) begin
					pair_q <= pair_q + AW'(1);
				end
			end

			// The sequence number advances once the last byte is loaded.
			if (out_load && out_last_d) begin
				seq_q <= seq_q + 32'd1;
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (packets.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers: the sample word and the output byte.
	always_ff @(posedge clk) begin
		if (take_in && samples.valid) begin
			a_s1 <= samples.chan_a_sample;
			b_s1 <= samples.chan_b_sample;
		end
		if (out_load) begin
			out_byte_q <= out_byte_d;
			out_last_q <= out_last_d;
		end
	end

	assign packets.valid       = out_valid_q;
	assign packets.packet_byte = out_byte_q;
	assign packets.packet_last = out_last_q;

endmodule
